>>> rtl/core/csnp_pkg.sv
// Shared types and constants for the contour splitter.
// Holds the request codes, port widths and the controller/datapath command and status structs.
// No dependencies.
package csnp_pkg;

    // Fixed port widths
    localparam int REQ_W   = 2;
    localparam int COORD_W = 16;
    localparam int SEG_W   = 10;

    // Default sizes
    localparam int DEF_MAX_CONTOUR = 1024;
    localparam int DEF_MAX_APPROX  = 16;
    localparam int DEF_COORD_BITS  = 16;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_CONTOUR = 2'd0,
        REQ_APPROX  = 2'd1,
        REQ_FINISH  = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_c;
        logic load_a;
        logic run_clr;
        logic emit_whole;
        logic scan_init;
        logic rd_en;
        logic insert;
        logic emit;
        logic emit_last;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic c_empty;
        logic a_empty;
        logic a_one;
        logic c_last;
        logic a_last;
        logic pipe_busy;
    } t_stat;

endpackage

>>> rtl/core/contour_split_at_nearest_points.sv
// Contour splitter at nearest points. A load transaction (contour or approximation
// point) is taken while idle, and loads may follow back to back. A finish
// transaction with N contour points and M approximation points, M of two or
// more, keeps busy high while each approximation point scans the contour memory
// through its single read port, one point a cycle, plus setup, a pipeline drain
// and a sorted insert; then the M segments come out back to back. With one
// approximation point the whole contour comes out as one segment on the next
// cycle and busy stays low; with an empty set nothing comes out. Segments are
// marked by o_valid for one cycle each and cannot be held off by the receiver.
// Depends on csnp_pkg, csnp_ctrl and csnp_dp.
module contour_split_at_nearest_points #(
    parameter int MAX_CONTOUR = csnp_pkg::DEF_MAX_CONTOUR,
    parameter int MAX_APPROX  = csnp_pkg::DEF_MAX_APPROX,
    parameter int COORD_BITS  = csnp_pkg::DEF_COORD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [csnp_pkg::REQ_W-1:0]          i_req_type,
    input  logic signed [csnp_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [csnp_pkg::COORD_W-1:0] i_point_y,
    output logic                                o_valid,
    output logic [csnp_pkg::SEG_W-1:0]          o_seg_start,
    output logic [csnp_pkg::SEG_W-1:0]          o_seg_end,
    output logic                                o_seg_final,
    output logic                                o_points_dropped
);
    import csnp_pkg::*;

    localparam int IW = $clog2(MAX_CONTOUR);
    localparam int AW = $clog2(MAX_APPROX);

    t_cmd          w_cmd;
    t_stat         w_stat;
    logic [IW-1:0] w_rd_addr;
    logic [AW-1:0] w_aidx;

    // Sequencer
    csnp_ctrl #(
        .MAX_CONTOUR (MAX_CONTOUR),
        .MAX_APPROX  (MAX_APPROX),
        .IW          (IW),
        .AW          (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (w_stat),
        .o_busy     (busy),
        .o_cmd      (w_cmd),
        .o_rd_addr  (w_rd_addr),
        .o_aidx     (w_aidx)
    );

    // Stores and arithmetic
    csnp_dp #(
        .MAX_CONTOUR (MAX_CONTOUR),
        .MAX_APPROX  (MAX_APPROX),
        .COORD_BITS  (COORD_BITS),
        .IW          (IW),
        .AW          (AW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_rd_addr        (w_rd_addr),
        .i_aidx           (w_aidx),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .o_stat           (w_stat),
        .o_valid          (o_valid),
        .o_seg_start      (o_seg_start),
        .o_seg_end        (o_seg_end),
        .o_seg_final      (o_seg_final),
        .o_points_dropped (o_points_dropped)
    );

`ifndef SYNTHESIS
    // A segment run continues without gaps until its final segment
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_seg_final) |=> o_valid)
        else $error("segment run broken before final segment");

    // Emission starts only after the distance pipeline has drained
    a_emit_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit || w_cmd.insert) |-> !w_stat.pipe_busy)
        else $error("list used while distance pipeline busy");

    // A new scan never overlaps the previous one
    a_scan_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_init |-> !w_stat.pipe_busy)
        else $error("scan started with pipeline busy");
`endif

endmodule

>>> rtl/core/csnp_dp.sv
// Datapath of the contour splitter: point stores, distance pipeline,
// sorted index list and output registers. Depends on csnp_pkg.
module csnp_dp #(
    parameter int MAX_CONTOUR = csnp_pkg::DEF_MAX_CONTOUR,
    parameter int MAX_APPROX  = csnp_pkg::DEF_MAX_APPROX,
    parameter int COORD_BITS  = csnp_pkg::DEF_COORD_BITS,
    parameter int IW          = $clog2(MAX_CONTOUR),
    parameter int AW          = $clog2(MAX_APPROX)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  csnp_pkg::t_cmd                      i_cmd,
    input  logic [IW-1:0]                       i_rd_addr,
    input  logic [AW-1:0]                       i_aidx,
    input  logic signed [csnp_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [csnp_pkg::COORD_W-1:0] i_point_y,
    output csnp_pkg::t_stat                     o_stat,
    output logic                                o_valid,
    output logic [csnp_pkg::SEG_W-1:0]          o_seg_start,
    output logic [csnp_pkg::SEG_W-1:0]          o_seg_end,
    output logic                                o_seg_final,
    output logic                                o_points_dropped
);
    import csnp_pkg::*;

    localparam int CW   = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int CNTW = $clog2(MAX_CONTOUR + 1);
    localparam int ACW  = $clog2(MAX_APPROX + 1);
    localparam int DW   = CW + 1;
    localparam int SQW  = 2 * DW;
    localparam logic signed [COORD_W-1:0] C_HI = COORD_W'((2 ** (CW - 1)) - 1);
    localparam logic signed [COORD_W-1:0] C_LO = -C_HI - COORD_W'(1);

    // Run state
    logic [CNTW-1:0]          r_nc;
    logic [ACW-1:0]           r_na;
    logic                     r_ovf;

    // Stores
    logic [2*CW-1:0]          r_cmem [MAX_CONTOUR];
    logic [2*CW-1:0]          r_amem [MAX_APPROX];
    logic [IW-1:0]            r_list [MAX_APPROX];
    logic [IW-1:0]            n_list [MAX_APPROX];

    // Distance pipeline
    logic [2*CW-1:0]          r_rd_data;
    logic                     r_v0, r_v1, r_v2;
    logic [IW-1:0]            r_i0, r_i1, r_i2;
    logic signed [CW-1:0]     r_ax, r_ay;
    logic signed [DW-1:0]     r_dx, r_dy;
    logic signed [SQW-1:0]    r_sqx, r_sqy;
    logic [SQW:0]             w_sum;
    logic [SQW:0]             r_best;
    logic [IW-1:0]            r_best_idx;
    logic                     r_have_best;

    logic signed [COORD_W-1:0] w_sx, w_sy;
    logic signed [CW-1:0]      w_px, w_py;
    logic [IW-1:0]             w_nc_last;

    // Saturate incoming coordinates to the stored range
    always_comb begin
        w_sx = i_point_x;
        w_sy = i_point_y;
        if (i_point_x > C_HI) w_sx = C_HI;
        if (i_point_x < C_LO) w_sx = C_LO;
        if (i_point_y > C_HI) w_sy = C_HI;
        if (i_point_y < C_LO) w_sy = C_LO;
    end

    assign w_px      = r_rd_data[CW-1:0];
    assign w_py      = r_rd_data[2*CW-1:CW];
    assign w_nc_last = IW'(r_nc - CNTW'(1));

    // Status toward the controller
    assign o_stat.c_empty   = (r_nc == '0);
    assign o_stat.a_empty   = (r_na == '0);
    assign o_stat.a_one     = (r_na == ACW'(1));
    assign o_stat.c_last    = (CNTW'(i_rd_addr) == r_nc - CNTW'(1));
    assign o_stat.a_last    = (ACW'(i_aidx) == r_na - ACW'(1));
    assign o_stat.pipe_busy = r_v0 | r_v1 | r_v2;

    // Counts and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc  <= '0;
            r_na  <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.run_clr) begin
            r_nc  <= '0;
            r_na  <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.load_c) begin
            if (r_nc < CNTW'(MAX_CONTOUR)) r_nc <= r_nc + CNTW'(1);
            else                           r_ovf <= 1'b1;
        end else if (i_cmd.load_a) begin
            if (r_na < ACW'(MAX_APPROX)) r_na <= r_na + ACW'(1);
            else                         r_ovf <= 1'b1;
        end
    end

    // Contour memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_c && r_nc < CNTW'(MAX_CONTOUR)) begin
            r_cmem[IW'(r_nc)] <= {w_sy[CW-1:0], w_sx[CW-1:0]};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_cmem[i_rd_addr];
        end
    end

    // Approximation point store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a && r_na < ACW'(MAX_APPROX)) begin
            r_amem[AW'(r_na)] <= {w_sy[CW-1:0], w_sx[CW-1:0]};
        end
        if (i_cmd.scan_init) begin
            r_ax <= r_amem[i_aidx][CW-1:0];
            r_ay <= r_amem[i_aidx][2*CW-1:CW];
        end
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_have_best <= 1'b0;
        end else begin
            r_v0 <= i_cmd.rd_en;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            if (i_cmd.scan_init)  r_have_best <= 1'b0;
            else if (r_v2)        r_have_best <= 1'b1;
        end
    end

    assign w_sum = {1'b0, SQW'(unsigned'(r_sqx))} + {1'b0, SQW'(unsigned'(r_sqy))};

    // Difference, square, then sum and keep the strict minimum
    always_ff @(posedge i_clk) begin
        r_i0  <= i_rd_addr;
        r_i1  <= r_i0;
        r_i2  <= r_i1;
        r_dx  <= DW'(w_px) - DW'(r_ax);
        r_dy  <= DW'(w_py) - DW'(r_ay);
        r_sqx <= r_dx * r_dx;
        r_sqy <= r_dy * r_dy;
        if (r_v2 && (!r_have_best || w_sum < r_best)) begin
            r_best     <= w_sum;
            r_best_idx <= r_i2;
        end
    end

    // Insert the new index into the sorted list of aidx entries
    always_comb begin
        for (int j = 0; j < MAX_APPROX; j++) begin
            n_list[j] = r_list[j];
            if (j <= int'(i_aidx)) begin
                if (j < int'(i_aidx) && r_list[j] <= r_best_idx) begin
                    n_list[j] = r_list[j];
                end else if (j > 0 && r_list[(j > 0) ? j - 1 : 0] > r_best_idx) begin
                    n_list[j] = r_list[(j > 0) ? j - 1 : 0];
                end else begin
                    n_list[j] = r_best_idx;
                end
            end
        end
    end

    // Update the list on insert, advance it by one on each emitted segment
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            r_list <= n_list;
        end else if (i_cmd.emit) begin
            for (int j = 0; j < MAX_APPROX - 1; j++) begin
                r_list[j] <= r_list[j + 1];
            end
        end
    end

    // Output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit | i_cmd.emit_whole;
        end
        o_seg_start      <= i_cmd.emit_whole ? '0 : SEG_W'(r_list[0]);
        o_seg_end        <= (i_cmd.emit_whole || i_cmd.emit_last) ? SEG_W'(w_nc_last)
                                                                  : SEG_W'(r_list[1]);
        o_seg_final      <= i_cmd.emit_whole | i_cmd.emit_last;
        o_points_dropped <= r_ovf;
    end

endmodule

>>> rtl/core/csnp_ctrl.sv
// Controller of the contour splitter: decodes transactions and sequences
// the nearest point scan, the list insertion and segment emission. Depends on csnp_pkg.
module csnp_ctrl #(
    parameter int MAX_CONTOUR = csnp_pkg::DEF_MAX_CONTOUR,
    parameter int MAX_APPROX  = csnp_pkg::DEF_MAX_APPROX,
    parameter int IW          = $clog2(MAX_CONTOUR),
    parameter int AW          = $clog2(MAX_APPROX)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [csnp_pkg::REQ_W-1:0]     i_req_type,
    input  csnp_pkg::t_stat                i_stat,
    output logic                           o_busy,
    output csnp_pkg::t_cmd                 o_cmd,
    output logic [IW-1:0]                  o_rd_addr,
    output logic [AW-1:0]                  o_aidx
);
    import csnp_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PREP   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_DRAIN  = 6'b001000,
        ST_INSERT = 6'b010000,
        ST_EMIT   = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_i, n_i;
    logic [AW-1:0] r_a, n_a;

    assign o_busy    = (r_state != ST_IDLE);
    assign o_rd_addr = r_i;
    assign o_aidx    = r_a;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_a     = r_a;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (t_req'(i_req_type))
                        REQ_CONTOUR: o_cmd.load_c = 1'b1;
                        REQ_APPROX:  o_cmd.load_a = 1'b1;
                        REQ_FINISH: begin
                            if (i_stat.c_empty || i_stat.a_empty) begin
                                o_cmd.run_clr = 1'b1;
                            end else if (i_stat.a_one) begin
                                o_cmd.emit_whole = 1'b1;
                                o_cmd.run_clr    = 1'b1;
                            end else begin
                                n_a     = '0;
                                n_state = ST_PREP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_PREP: begin
                o_cmd.scan_init = 1'b1;
                n_i             = '0;
                n_state         = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_stat.c_last) n_state = ST_DRAIN;
                else               n_i     = r_i + IW'(1);
            end
            ST_DRAIN: begin
                if (!i_stat.pipe_busy) n_state = ST_INSERT;
            end
            ST_INSERT: begin
                o_cmd.insert = 1'b1;
                if (i_stat.a_last) begin
                    n_a     = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_a     = r_a + AW'(1);
                    n_state = ST_PREP;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.a_last) begin
                    o_cmd.emit_last = 1'b1;
                    o_cmd.run_clr   = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    n_a = r_a + AW'(1);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and loop counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_a     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_a     <= n_a;
        end
    end

endmodule

>>> bench/contour_split_at_nearest_points_tb.sv
`timescale 1ns / 100ps
// Testbench for contour_split_at_nearest_points: drives point and finish transactions and
// checks every emitted segment against an in-bench nearest-point splitter model.
// Depends on csnp_pkg and the contour_split_at_nearest_points RTL.
module contour_split_at_nearest_points_tb;
    import csnp_pkg::*;

    typedef struct {
        logic [SEG_W-1:0] seg_start;
        logic [SEG_W-1:0] seg_end;
        logic             seg_final;
        logic             dropped;
    } t_segment;

    // Tracks loaded points and the segments each finish must produce
    class split_scoreboard;
        logic signed [COORD_W-1:0] cont_x [DEF_MAX_CONTOUR];
        logic signed [COORD_W-1:0] cont_y [DEF_MAX_CONTOUR];
        logic signed [COORD_W-1:0] appr_x [DEF_MAX_APPROX];
        logic signed [COORD_W-1:0] appr_y [DEF_MAX_APPROX];
        int       n_cont;
        int       n_appr;
        bit       overflow;
        t_segment seg_q [$];
        int       n_err;
        int       n_seen;
        int       n_finish;

        function longint sq_dist(input int ci, input int ai);
            longint dx;
            longint dy;
            dx = longint'(cont_x[ci]) - longint'(appr_x[ai]);
            dy = longint'(cont_y[ci]) - longint'(appr_y[ai]);
            return dx * dx + dy * dy;
        endfunction

        function void push_segment(input int s, input int e, input bit fin);
            t_segment sg;
            sg.seg_start = SEG_W'(s);
            sg.seg_end   = SEG_W'(e);
            sg.seg_final = fin;
            sg.dropped   = overflow;
            seg_q = {seg_q, sg};
        endfunction

        // Update the stores for an accepted transaction; a finish queues its segments
        function void note_request(input t_req req, input logic signed [COORD_W-1:0] x,
                                   input logic signed [COORD_W-1:0] y);
            int     nearest [DEF_MAX_APPROX];
            int     best;
            int     key;
            int     j;
            longint best_d;
            longint d;
            // Coordinates are stored as given: COORD_BITS equals the port width here
            case (req)
                REQ_CONTOUR: begin
                    if (n_cont < DEF_MAX_CONTOUR) begin
                        cont_x[n_cont] = x;
                        cont_y[n_cont] = y;
                        n_cont++;
                    end else begin
                        overflow = 1'b1;
                    end
                end
                REQ_APPROX: begin
                    if (n_appr < DEF_MAX_APPROX) begin
                        appr_x[n_appr] = x;
                        appr_y[n_appr] = y;
                        n_appr++;
                    end else begin
                        overflow = 1'b1;
                    end
                end
                REQ_FINISH: begin
                    n_finish++;
                    if (n_cont > 0 && n_appr == 1) begin
                        push_segment(0, n_cont - 1, 1'b1);
                    end else if (n_cont > 0 && n_appr > 1) begin
                        // Find the nearest contour index per point; first index wins ties
                        for (int a = 0; a < n_appr; a++) begin
                            best   = 0;
                            best_d = sq_dist(0, a);
                            for (int i = 1; i < n_cont; i++) begin
                                d = sq_dist(i, a);
                                if (d < best_d) begin
                                    best_d = d;
                                    best   = i;
                                end
                            end
                            nearest[a] = best;
                        end
                        // Sort ascending
                        for (int i = 1; i < n_appr; i++) begin
                            key = nearest[i];
                            j   = i;
                            while (j > 0 && nearest[j-1] > key) begin
                                nearest[j] = nearest[j-1];
                                j--;
                            end
                            nearest[j] = key;
                        end
                        for (int i = 0; i + 1 < n_appr; i++)
                            push_segment(nearest[i], nearest[i+1], 1'b0);
                        push_segment(nearest[n_appr-1], n_cont - 1, 1'b1);
                    end
                    // Clear the run state whether or not anything was emitted
                    n_cont   = 0;
                    n_appr   = 0;
                    overflow = 1'b0;
                end
                default: ;
            endcase
        endfunction

        // Compare a strobed segment with the oldest expected one
        function void check_segment(input logic [SEG_W-1:0] s, input logic [SEG_W-1:0] e,
                                    input logic fin, input logic drop);
            t_segment ex;
            n_seen++;
            if (seg_q.size() == 0) begin
                $display("%0t: unexpected segment start=%0d end=%0d final=%0b dropped=%0b",
                         $time, s, e, fin, drop);
                n_err++;
                return;
            end
            ex = seg_q.pop_front();
            if (s !== ex.seg_start) begin
                $display("%0t: seg_start expected %0d actual %0d", $time, ex.seg_start, s);
                n_err++;
            end
            if (e !== ex.seg_end) begin
                $display("%0t: seg_end expected %0d actual %0d", $time, ex.seg_end, e);
                n_err++;
            end
            if (fin !== ex.seg_final) begin
                $display("%0t: seg_final expected %0b actual %0b", $time, ex.seg_final, fin);
                n_err++;
            end
            if (drop !== ex.dropped) begin
                $display("%0t: points_dropped expected %0b actual %0b", $time, ex.dropped, drop);
                n_err++;
            end
        endfunction

        function int pending();
            return seg_q.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [REQ_W-1:0]          i_req_type;
    logic signed [COORD_W-1:0] i_point_x;
    logic signed [COORD_W-1:0] i_point_y;
    logic                      o_valid;
    logic [SEG_W-1:0]          o_seg_start;
    logic [SEG_W-1:0]          o_seg_end;
    logic                      o_seg_final;
    logic                      o_points_dropped;

    split_scoreboard sb;
    bit              calm;
    int              n_items;

    contour_split_at_nearest_points i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_req_type       (i_req_type),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .o_valid          (o_valid),
        .o_seg_start      (o_seg_start),
        .o_seg_end        (o_seg_end),
        .o_seg_final      (o_seg_final),
        .o_points_dropped (o_points_dropped)
    );

    always #2 i_clk = ~i_clk;

    // Check strobed segments, then note the transaction taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                sb.check_segment(o_seg_start, o_seg_end, o_seg_final, o_points_dropped);
            if (start && !busy)
                sb.note_request(t_req'(i_req_type), i_point_x, i_point_y);
        end
    end

    // Pick a coordinate: full range, tight cluster (ties), extremes, or mid range
    function automatic logic signed [COORD_W-1:0] pick_coord(input int mode);
        case (mode)
            0: return COORD_W'($urandom);
            1: return COORD_W'($urandom_range(0, 24)) - 16'd12;
            2: begin
                case ($urandom_range(0, 5))
                    0: return 16'sh8000;
                    1: return 16'sh8001;
                    2: return 16'shFFFF;
                    3: return 16'sh0000;
                    4: return 16'sh0001;
                    default: return 16'sh7FFF;
                endcase
            end
            default: return COORD_W'($urandom_range(0, 200)) - 16'd100;
        endcase
    endfunction

    // Send one transaction, idling first at random, and hold it until taken
    task automatic send_req(input t_req req, input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < 24)
            gap++;
        repeat (gap) begin
            @(negedge i_clk);
            start      = 1'b0;
            i_req_type = REQ_W'($urandom);
            i_point_x  = COORD_W'($urandom);
            i_point_y  = COORD_W'($urandom);
        end
        @(negedge i_clk);
        start      = 1'b1;
        i_req_type = req;
        i_point_x  = x;
        i_point_y  = y;
        do @(posedge i_clk); while (busy);
        if (req != REQ_NONE)
            n_items++;
    endtask

    // Load a contour and approximation points, optionally interleaved, then finish
    task automatic send_run(input int n_c, input int n_a, input int mode, input bit mixed);
        logic signed [COORD_W-1:0] px [$];
        logic signed [COORD_W-1:0] py [$];
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        int c_left;
        int a_left;
        int k;
        bit take_c;
        c_left = n_c;
        a_left = n_a;
        while (c_left + a_left > 0) begin
            if ($urandom_range(0, 99) < 4)
                send_req(REQ_NONE, COORD_W'($urandom), COORD_W'($urandom));
            take_c = (c_left > 0) && (!mixed || a_left == 0 || $urandom_range(0, 1) == 1);
            if (take_c) begin
                x = pick_coord(mode);
                y = pick_coord(mode);
                px = {px, x};
                py = {py, y};
                send_req(REQ_CONTOUR, x, y);
                c_left--;
            end else begin
                // Mostly place approximation points close to a loaded contour point
                if (px.size() > 0 && $urandom_range(0, 3) != 0) begin
                    k = $urandom_range(0, px.size() - 1);
                    x = px[k] + COORD_W'($urandom_range(0, 6)) - 16'd3;
                    y = py[k] + COORD_W'($urandom_range(0, 6)) - 16'd3;
                end else begin
                    x = pick_coord(mode);
                    y = pick_coord(mode);
                end
                send_req(REQ_APPROX, x, y);
                a_left--;
            end
        end
        send_req(REQ_FINISH, pick_coord(0), pick_coord(0));
    endtask

    // Hard stop in case the block hangs
    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int run_no;
        int kind;
        sb         = new();
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req_type = REQ_NONE;
        i_point_x  = '0;
        i_point_y  = '0;
        calm       = 1'b0;
        n_items    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty sets, ignored request, single point, ties and extremes
        send_req(REQ_FINISH, 16'sh0000, 16'sh0000);
        send_req(REQ_NONE, 16'sh8000, 16'sh7FFF);
        send_req(REQ_CONTOUR, 16'sh7FFF, 16'sh8000);
        send_req(REQ_FINISH, 16'sh0000, 16'sh0000);
        send_req(REQ_APPROX, 16'sh0000, 16'sh0000);
        send_req(REQ_FINISH, 16'sh0000, 16'sh0000);
        send_req(REQ_CONTOUR, 16'sh8000, 16'sh8000);
        send_req(REQ_CONTOUR, 16'sh7FFF, 16'sh7FFF);
        send_req(REQ_CONTOUR, 16'sh0000, 16'sh0000);
        send_req(REQ_APPROX, 16'sh0001, 16'sh0001);
        send_req(REQ_FINISH, 16'shFFFF, 16'shFFFF);
        send_req(REQ_CONTOUR, 16'sh0000, 16'sh0000);
        send_req(REQ_CONTOUR, 16'sh0005, 16'sh0005);
        send_req(REQ_CONTOUR, 16'sh0000, 16'sh0000);
        send_req(REQ_CONTOUR, 16'sh8000, 16'sh7FFF);
        send_req(REQ_NONE, 16'sh5555, 16'shAAAA);
        send_req(REQ_CONTOUR, 16'sh7FFF, 16'sh8000);
        send_req(REQ_APPROX, 16'sh7FFF, 16'sh8000);
        send_req(REQ_APPROX, 16'sh0000, 16'sh0000);
        send_req(REQ_APPROX, 16'sh8000, 16'sh7FFF);
        send_req(REQ_APPROX, 16'sh0002, 16'sh0002);
        send_req(REQ_FINISH, 16'sh0000, 16'sh0000);

        // Random runs: mostly well formed, some overflowing, mixed or empty
        run_no = 0;
        while (n_items < 500) begin
            calm = (run_no >= 12 && run_no < 20);
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                send_run($urandom_range(1, 24),
                         ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                      : $urandom_range(1, 6),
                         $urandom_range(0, 3), 1'b0);
            end else if (kind < 80) begin
                send_run($urandom_range(1, 10), $urandom_range(17, 19),
                         $urandom_range(0, 3), $urandom_range(0, 1));
            end else if (kind < 90) begin
                send_run($urandom_range(1, 16), $urandom_range(1, 8),
                         $urandom_range(0, 3), 1'b1);
            end else begin
                case ($urandom_range(0, 2))
                    0: send_run(0, 0, 0, 1'b0);
                    1: send_run($urandom_range(1, 6), 0, $urandom_range(0, 3), 1'b0);
                    default: send_run(0, $urandom_range(1, 6), $urandom_range(0, 3), 1'b0);
                endcase
            end
            // Hold off new transactions until the block has drained
            if (run_no == 2 || $urandom_range(0, 7) == 0) begin
                @(negedge i_clk);
                start = 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
            end
            run_no++;
        end
        calm = 1'b0;

        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);

        $display("Covered %0d point/finish transactions in %0d finish runs, %0d segments checked",
                 n_items, sb.n_finish, sb.n_seen);
        $display("including empty sets, ties, ignored requests and store overflow");
        if (sb.n_err == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> contour_split_at_nearest_points.f
rtl/core/csnp_pkg.sv
rtl/core/csnp_dp.sv
rtl/core/csnp_ctrl.sv
rtl/core/contour_split_at_nearest_points.sv
bench/contour_split_at_nearest_points_tb.sv
